@@ hw/rtl/rdnt_pkg.sv @@
package rdnt_pkg;

  localparam int FRAC_BITS       = 16;
  localparam int COS_TABLE_DEPTH = 256;
  localparam int IDX_BITS        = $clog2(COS_TABLE_DEPTH);
  localparam int TAPER_W         = FRAC_BITS + 1;
  localparam int MAG_W           = 33;

  localparam logic [2:0] REG_LAYER_WIDTH = 3'd0;
  localparam logic [2:0] REG_MAX_COEF    = 3'd1;
  localparam logic [2:0] REG_REF_VEL_X   = 3'd2;
  localparam logic [2:0] REG_REF_VEL_Y   = 3'd3;
  localparam logic [2:0] REG_REF_VEL_Z   = 3'd4;
  localparam logic [2:0] REG_DIMENSIONS  = 3'd5;

  localparam logic [1:0] DIMS_TWO = 2'd2;

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;

  localparam int TAYLOR_DIV [12] = '{2, 12, 30, 56, 90, 132, 182, 240, 306, 380, 462, 552};

  typedef struct packed {
    logic [30:0]        wall_distance;
    logic [30:0]        node_volume;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } node_t;

  typedef struct packed {
    logic [30:0]        diag_add;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
  } term_t;

  typedef struct packed {
    logic [30:0]        layer_width;
    logic [30:0]        max_coefficient;
    logic signed [31:0] ref_vel_x;
    logic signed [31:0] ref_vel_y;
    logic signed [31:0] ref_vel_z;
    logic [1:0]         dimensions;
  } cfg_t;

  // per-node data carried down the pipe
  typedef struct packed {
    logic                   in_layer;
    logic                   zero_z;
    logic [30:0]            node_volume;
    logic [2:0]             diff_neg;
    logic [2:0][MAG_W-1:0]  diff_mag;
  } flight_t;

  typedef logic [TAPER_W-1:0] taper_rom_t [COS_TABLE_DEPTH];

  function automatic logic signed [63:0] cos_q30(input logic [63:0] a);
    logic [63:0]        a2;
    logic [63:0]        mag;
    logic signed [63:0] sum;
    a2  = (a * a) >> 30;
    mag = ONE_Q30;
    sum = $signed(ONE_Q30);
    for (int n = 1; n <= 12; n++) begin
      mag = ((mag * a2) >> 30) / 64'(TAYLOR_DIV[n-1]);
      if (n % 2 == 1) sum = sum - $signed(mag);
      else sum = sum + $signed(mag);
    end
    if (sum > $signed(ONE_Q30)) sum = $signed(ONE_Q30);
    if (sum < -$signed(ONE_Q30)) sum = -$signed(ONE_Q30);
    return sum;
  endfunction

  function automatic taper_rom_t build_taper();
    taper_rom_t         rom;
    logic               flip;
    logic [63:0]        j;
    logic [63:0]        a;
    logic signed [63:0] cv;
    logic [63:0]        t30;
    logic [63:0]        e;
    for (int i = 0; i < COS_TABLE_DEPTH; i++) begin
      flip = (2 * i > COS_TABLE_DEPTH);
      j    = flip ? 64'(COS_TABLE_DEPTH - i) : 64'(i);
      a    = PI_Q30 * j / COS_TABLE_DEPTH;
      cv   = cos_q30(a);
      if (flip) cv = -cv;
      t30  = 64'($signed(ONE_Q30) + cv) >> 1;
      e    = (((t30 << 1) >> (30 - FRAC_BITS)) + 64'd1) >> 1;
      rom[i] = e[TAPER_W-1:0];
    end
    return rom;
  endfunction

  localparam taper_rom_t TAPER_ROM = build_taper();

endpackage

@@ hw/rtl/rdnt_front.sv @@
module rdnt_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic              node_valid,
  input  rdnt_pkg::node_t   node,
  input  rdnt_pkg::cfg_t    cfg,
  output logic              fl_valid,
  output rdnt_pkg::flight_t fl,
  output logic [31:0]       rem
);
  import rdnt_pkg::*;

  flight_t            fl_next;
  logic signed [32:0] diff [3];
  logic signed [31:0] refv [3];
  logic signed [31:0] vel  [3];

  always_comb begin
    refv[0] = cfg.ref_vel_x;
    refv[1] = cfg.ref_vel_y;
    refv[2] = cfg.ref_vel_z;
    vel[0]  = node.vel_x;
    vel[1]  = node.vel_y;
    vel[2]  = node.vel_z;
    fl_next.in_layer    = (cfg.layer_width != '0) && (node.wall_distance < cfg.layer_width);
    fl_next.zero_z      = (cfg.dimensions == DIMS_TWO);
    fl_next.node_volume = node.node_volume;
    for (int k = 0; k < 3; k++) begin
      diff[k] = 33'(refv[k]) - 33'(vel[k]);
      fl_next.diff_neg[k] = diff[k][32];
      fl_next.diff_mag[k] = diff[k][32] ? MAG_W'(-diff[k]) : MAG_W'(diff[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fl_valid <= 1'b0;
    end else if (advance) begin
      fl_valid <= node_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      fl  <= fl_next;
      rem <= {1'b0, node.wall_distance};
    end
  end

endmodule

@@ hw/rtl/rdnt_div.sv @@
module rdnt_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic [30:0]                   layer_width,
  input  logic                          in_valid,
  input  rdnt_pkg::flight_t             in_fl,
  input  logic [31:0]                   in_rem,
  output logic                          out_valid,
  output rdnt_pkg::flight_t             out_fl,
  output logic [rdnt_pkg::IDX_BITS-1:0] out_idx
);
  import rdnt_pkg::*;

  // one restoring quotient bit per stage: idx = distance * depth / width
  logic                v_q   [IDX_BITS];
  flight_t             fl_q  [IDX_BITS];
  logic [31:0]         rem_q [IDX_BITS];
  logic [IDX_BITS-1:0] quo_q [IDX_BITS];

  for (genvar k = 0; k < IDX_BITS; k++) begin : g_step
    logic                v_in;
    flight_t             fl_in;
    logic [31:0]         rem_in;
    logic [IDX_BITS-1:0] quo_in;
    logic [32:0]         shifted;
    logic                take;

    if (k == 0) begin : g_first
      assign v_in   = in_valid;
      assign fl_in  = in_fl;
      assign rem_in = in_rem;
      assign quo_in = '0;
    end else begin : g_rest
      assign v_in   = v_q[k-1];
      assign fl_in  = fl_q[k-1];
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign shifted = {rem_in, 1'b0};
    assign take    = shifted >= {2'b00, layer_width};

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k] <= 1'b0;
      end else if (advance) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        fl_q[k]  <= fl_in;
        rem_q[k] <= take ? 32'(shifted - {2'b00, layer_width}) : shifted[31:0];
        quo_q[k] <= {quo_in[IDX_BITS-2:0], take};
      end
    end
  end

  assign out_valid = v_q[IDX_BITS-1];
  assign out_fl    = fl_q[IDX_BITS-1];
  assign out_idx   = quo_q[IDX_BITS-1];

endmodule

@@ hw/rtl/rdnt_mul.sv @@
module rdnt_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic [30:0]                   max_coefficient,
  input  logic                          in_valid,
  input  rdnt_pkg::flight_t             in_fl,
  input  logic [rdnt_pkg::IDX_BITS-1:0] in_idx,
  output logic                          term_valid,
  output rdnt_pkg::term_t               term
);
  import rdnt_pkg::*;

  localparam int CP_W  = 31 + TAPER_W;
  localparam int C_W   = CP_W - FRAC_BITS;
  localparam int MP_W  = C_W + 31;
  localparam int M_W   = MP_W - FRAC_BITS;
  localparam int HI_W  = M_W - 32;
  localparam int PLO_W = 32 + MAG_W;
  localparam int PHI_W = HI_W + MAG_W;
  localparam int TOT_W = M_W + MAG_W + 1;
  localparam int R_W   = TOT_W - FRAC_BITS;

  localparam logic [CP_W-1:0]  HALF_C = CP_W'(1) << (FRAC_BITS - 1);
  localparam logic [MP_W-1:0]  HALF_M = MP_W'(1) << (FRAC_BITS - 1);
  localparam logic [TOT_W-1:0] HALF_F = TOT_W'(1) << (FRAC_BITS - 1);

  // taper lookup
  logic               v_a;
  flight_t            fl_a;
  logic [TAPER_W-1:0] taper_a;
  // coefficient
  logic               v_b;
  flight_t            fl_b;
  logic [C_W-1:0]     c_b;
  logic [CP_W-1:0]    cp;
  // coefficient times volume
  logic               v_c;
  flight_t            fl_c;
  logic [M_W-1:0]     m_c;
  logic [MP_W-1:0]    mp;
  // force partial products
  logic               v_d;
  logic               zero_z_d;
  logic [2:0]         neg_d;
  logic [30:0]        diag_d;
  logic [PLO_W-1:0]   plo_d [3];
  logic [PHI_W-1:0]   phi_d [3];

  logic [TOT_W-1:0]   tot   [3];
  logic [R_W-1:0]     r     [3];
  logic [R_W-1:0]     limit [3];
  logic [31:0]        f     [3];

  assign cp = CP_W'(max_coefficient) * CP_W'(taper_a) + HALF_C;
  assign mp = MP_W'(c_b) * MP_W'(fl_b.node_volume) + HALF_M;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      tot[k]   = (TOT_W'(phi_d[k]) << 32) + TOT_W'(plo_d[k]) + HALF_F;
      r[k]     = tot[k][TOT_W-1:FRAC_BITS];
      limit[k] = neg_d[k] ? R_W'(33'h080000000) : R_W'(33'h07FFFFFFF);
      if (r[k] > limit[k]) r[k] = limit[k];
      f[k] = neg_d[k] ? 32'(-r[k][31:0]) : r[k][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a        <= 1'b0;
      v_b        <= 1'b0;
      v_c        <= 1'b0;
      v_d        <= 1'b0;
      term_valid <= 1'b0;
    end else if (advance) begin
      v_a        <= in_valid;
      v_b        <= v_a;
      v_c        <= v_b;
      v_d        <= v_c;
      term_valid <= v_d;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      fl_a    <= in_fl;
      taper_a <= in_fl.in_layer ? TAPER_ROM[in_idx] : '0;
      fl_b    <= fl_a;
      c_b     <= cp[CP_W-1:FRAC_BITS];
      fl_c    <= fl_b;
      m_c     <= mp[MP_W-1:FRAC_BITS];
      zero_z_d <= fl_c.zero_z;
      neg_d    <= fl_c.diff_neg;
      diag_d   <= (m_c > M_W'(31'h7FFFFFFF)) ? 31'h7FFFFFFF : m_c[30:0];
      for (int k = 0; k < 3; k++) begin
        plo_d[k] <= PLO_W'(m_c[31:0]) * PLO_W'(fl_c.diff_mag[k]);
        phi_d[k] <= PHI_W'(m_c[M_W-1:32]) * PHI_W'(fl_c.diff_mag[k]);
      end
      term.diag_add <= diag_d;
      term.force_x  <= f[0];
      term.force_y  <= f[1];
      term.force_z  <= zero_z_d ? 32'sd0 : f[2];
    end
  end

endmodule

@@ hw/rtl/rayleigh_damping_node_term.sv @@
// Pipe: an accepted node word passes the front stage, 8 quotient-bit stages of
// the table index divider, taper table, two scale multiplies, force partial
// products and the output register on its way to its term word.
// Throughput: one node per cycle; the whole pipe holds while the output word stalls.
// Reset: synchronous rst empties the pipe and loads the register defaults
// (width 1.0, coefficient 0, reference velocity 0, three dimensions).
module rayleigh_damping_node_term (
  input  logic            clk,
  input  logic            rst,
  input  logic            node_valid,
  output logic            node_stall,
  input  rdnt_pkg::node_t node,
  output logic            term_valid,
  input  logic            term_stall,
  output rdnt_pkg::term_t term,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [31:0]     cfg_data
);
  import rdnt_pkg::*;

  cfg_t                cfg;
  logic                advance;
  logic                f_valid;
  flight_t             f_fl;
  logic [31:0]         f_rem;
  logic                d_valid;
  flight_t             d_fl;
  logic [IDX_BITS-1:0] d_idx;

  // hold every stage while the finished word waits
  assign advance    = !(term_valid && term_stall);
  assign node_stall = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.layer_width     <= 31'd65536;
      cfg.max_coefficient <= '0;
      cfg.ref_vel_x       <= '0;
      cfg.ref_vel_y       <= '0;
      cfg.ref_vel_z       <= '0;
      cfg.dimensions      <= 2'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LAYER_WIDTH: cfg.layer_width     <= cfg_data[30:0];
        REG_MAX_COEF:    cfg.max_coefficient <= cfg_data[30:0];
        REG_REF_VEL_X:   cfg.ref_vel_x       <= cfg_data;
        REG_REF_VEL_Y:   cfg.ref_vel_y       <= cfg_data;
        REG_REF_VEL_Z:   cfg.ref_vel_z       <= cfg_data;
        REG_DIMENSIONS:  cfg.dimensions      <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  rdnt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .node_valid (node_valid),
    .node       (node),
    .cfg        (cfg),
    .fl_valid   (f_valid),
    .fl         (f_fl),
    .rem        (f_rem)
  );

  rdnt_div u_div (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .layer_width (cfg.layer_width),
    .in_valid    (f_valid),
    .in_fl       (f_fl),
    .in_rem      (f_rem),
    .out_valid   (d_valid),
    .out_fl      (d_fl),
    .out_idx     (d_idx)
  );

  rdnt_mul u_mul (
    .clk             (clk),
    .rst             (rst),
    .advance         (advance),
    .max_coefficient (cfg.max_coefficient),
    .in_valid        (d_valid),
    .in_fl           (d_fl),
    .in_idx          (d_idx),
    .term_valid      (term_valid),
    .term            (term)
  );

`ifndef SYNTH
  a_stall_only_on_blocked_output: assert property (@(posedge clk) disable iff (rst)
    node_stall == (term_valid && term_stall))
    else $error("input stall does not follow the blocked output");

  a_two_dims_zero_z: assert property (@(posedge clk) disable iff (rst)
    term_valid && (cfg.dimensions == DIMS_TWO) |-> term.force_z == 32'sd0)
    else $error("z force nonzero with two dimensions");

  a_zero_diag_zero_force: assert property (@(posedge clk) disable iff (rst)
    term_valid && (term.diag_add == 31'd0) |->
      (term.force_x == 32'sd0) && (term.force_y == 32'sd0) && (term.force_z == 32'sd0))
    else $error("force without damping");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !term_valid)
    else $error("word out of reset");
`endif

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import rdnt_pkg::*;

  logic        clk;
  logic        rst;
  logic        node_valid;
  logic        node_stall;
  node_t       node;
  logic        term_valid;
  logic        term_stall;
  term_t       term;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  rayleigh_damping_node_term uut (
    .clk(clk), .rst(rst),
    .node_valid(node_valid), .node_stall(node_stall), .node(node),
    .term_valid(term_valid), .term_stall(term_stall), .term(term),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow of the register file
  logic [30:0]        sh_width;
  logic [30:0]        sh_coef;
  logic signed [31:0] sh_ref [3];
  logic [1:0]         sh_dims;
  logic [16:0]        taper [COS_TABLE_DEPTH];

  node_t pending_nodes [$];
  term_t expected_terms [$];
  int    errors;
  int    nodes_sent;
  int    terms_seen;
  bit    sender_hold;

  function automatic logic [63:0] taylor_cos(input logic [63:0] a);
    logic [63:0] a2;
    logic [63:0] mag;
    logic [63:0] sum;
    a2 = (a * a) >> 30;
    mag = 64'd1 << 30;
    sum = 64'd1 << 30;
    for (int n = 1; n <= 12; n++) begin
      mag = ((mag * a2) >> 30) / 64'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) sum = sum - mag;
      else sum = sum + mag;
    end
    if ($signed(sum) > $signed(64'd1 << 30)) sum = 64'd1 << 30;
    if ($signed(sum) < -$signed(64'd1 << 30)) sum = -(64'd1 << 30);
    return sum;
  endfunction

  task automatic fill_taper();
    bit          flip;
    logic [63:0] j;
    logic [63:0] cv;
    logic [63:0] t30;
    for (int i = 0; i < COS_TABLE_DEPTH; i++) begin
      flip = (2 * i > COS_TABLE_DEPTH);
      j = flip ? 64'(COS_TABLE_DEPTH - i) : 64'(i);
      cv = taylor_cos(64'd3373259426 * j / COS_TABLE_DEPTH);
      if (flip) cv = -cv;
      t30 = ((64'd1 << 30) + cv) >> 1;
      taper[i] = 17'((((t30 << 1) >> (30 - FRAC_BITS)) + 1) >> 1);
    end
  endtask

  function automatic logic [31:0] damp_force(input logic [63:0] m, input logic signed [32:0] diff);
    bit           neg;
    logic [32:0]  b;
    logic [127:0] p;
    logic [127:0] r;
    logic [127:0] lim;
    neg = diff < 0;
    b = neg ? 33'(-diff) : 33'(diff);
    p = 128'(m) * 128'(b);
    r = (p + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    if (r > lim) r = lim;
    return neg ? 32'(-r) : r[31:0];
  endfunction

  function automatic term_t node_term(input node_t n);
    term_t       t;
    logic [63:0] idx;
    logic [63:0] c;
    logic [63:0] m;
    c = 0;
    if (sh_width != 0 && n.wall_distance < sh_width) begin
      idx = 64'(n.wall_distance) * COS_TABLE_DEPTH / 64'(sh_width);
      if (idx >= COS_TABLE_DEPTH) idx = COS_TABLE_DEPTH - 1;
      c = (64'(sh_coef) * 64'(taper[idx]) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    end
    m = (c * 64'(n.node_volume) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    t.diag_add = (m > 64'h7fff_ffff) ? 31'h7fff_ffff : m[30:0];
    t.force_x = damp_force(m, 33'(sh_ref[0]) - 33'(n.vel_x));
    t.force_y = damp_force(m, 33'(sh_ref[1]) - 33'(n.vel_y));
    t.force_z = (sh_dims == DIMS_TWO) ? 32'sd0 :
                damp_force(m, 33'(sh_ref[2]) - 33'(n.vel_z));
    return t;
  endfunction

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // driver
  int send_gap;
  always @(posedge clk) begin
    if (rst) begin
      node_valid <= 0;
      send_gap <= $urandom_range(0, 10);
    end else begin
      if (node_valid && !node_stall) begin
        expected_terms.push_back(node_term(node));
        nodes_sent++;
      end
      if (!node_valid || !node_stall) begin
        if (send_gap > 0 && !(node_valid && !node_stall)) begin
          send_gap <= send_gap - 1;
          node_valid <= 0;
        end else if (node_valid && !node_stall) begin
          // word left; draw the gap before the next one
          send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
          if ($urandom_range(0, 1) && pending_nodes.size() > 0 && !sender_hold) begin
            node <= pending_nodes.pop_front();
            node_valid <= 1;
          end else begin
            node_valid <= 0;
          end
        end else if (pending_nodes.size() > 0 && !sender_hold) begin
          node <= pending_nodes.pop_front();
          node_valid <= 1;
        end
      end
    end
  end

  // monitor
  int recv_gap;
  int recv_draw;
  term_t want;
  always @(posedge clk) begin
    if (rst) begin
      term_stall <= 0;
      recv_gap <= 0;
    end else begin
      if (term_valid && !term_stall) begin
        terms_seen++;
        if (expected_terms.size() == 0) begin
          $display("%0t: unexpected term %h", $time, term);
          errors++;
        end else begin
          want = expected_terms.pop_front();
          if (term.diag_add !== want.diag_add)
            $display("%0t: diag_add expected %h actual %h", $time, want.diag_add, term.diag_add);
          if (term.force_x !== want.force_x)
            $display("%0t: force_x expected %h actual %h", $time, want.force_x, term.force_x);
          if (term.force_y !== want.force_y)
            $display("%0t: force_y expected %h actual %h", $time, want.force_y, term.force_y);
          if (term.force_z !== want.force_z)
            $display("%0t: force_z expected %h actual %h", $time, want.force_z, term.force_z);
          if (term !== want) errors++;
        end
        recv_draw = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
        recv_gap <= (recv_draw > 0) ? recv_draw - 1 : 0;
        term_stall <= (recv_draw > 0);
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        term_stall <= 1;
      end else begin
        term_stall <= 0;
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      REG_LAYER_WIDTH: sh_width = val[30:0];
      REG_MAX_COEF:    sh_coef = val[30:0];
      REG_REF_VEL_X:   sh_ref[0] = val;
      REG_REF_VEL_Y:   sh_ref[1] = val;
      REG_REF_VEL_Z:   sh_ref[2] = val;
      REG_DIMENSIONS:  sh_dims = val[1:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_nodes.size() > 0 || node_valid || expected_terms.size() > 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic node_t rand_node(input bit inside_layer);
    node_t n;
    n.wall_distance = 31'($urandom);
    if (inside_layer && sh_width != 0) n.wall_distance = 31'({1'b0, $urandom} % sh_width);
    case ($urandom_range(0, 3))
      0: n.node_volume = 31'($urandom_range(0, 1 << 20));
      1: n.node_volume = 31'($urandom_range(1 << 14, 1 << 18));
      default: n.node_volume = 31'($urandom);
    endcase
    n.vel_x = $urandom;
    n.vel_y = $urandom;
    n.vel_z = $urandom;
    if ($urandom_range(0, 2) == 0) begin
      n.vel_x = $urandom_range(0, 1 << 18) - (1 << 17);
      n.vel_y = $urandom_range(0, 1 << 18) - (1 << 17);
      n.vel_z = $urandom_range(0, 1 << 18) - (1 << 17);
    end
    return n;
  endfunction

  task automatic random_config();
    logic [31:0] w;
    case ($urandom_range(0, 4))
      0: w = 32'h7fff_ffff;
      1: w = $urandom_range(1, 300);
      2: w = 0;
      default: w = $urandom_range(1 << 12, 1 << 24);
    endcase
    write_reg(REG_LAYER_WIDTH, w);
    case ($urandom_range(0, 3))
      0: write_reg(REG_MAX_COEF, 32'h7fff_ffff);
      1: write_reg(REG_MAX_COEF, 0);
      default: write_reg(REG_MAX_COEF, $urandom_range(0, 1 << 22));
    endcase
    write_reg(REG_REF_VEL_X, $urandom);
    write_reg(REG_REF_VEL_Y, $urandom_range(0, 1) ? $urandom : 32'h8000_0000);
    write_reg(REG_REF_VEL_Z, $urandom_range(0, 1) ? $urandom : 32'h7fff_ffff);
    write_reg(REG_DIMENSIONS, $urandom_range(0, 3));
  endtask

  node_t dn;
  initial begin
    errors = 0;
    nodes_sent = 0;
    terms_seen = 0;
    sender_hold = 0;
    rst = 1;
    cfg_we = 0;
    cfg_index = 0;
    cfg_data = 0;
    node = '0;
    node_valid = 0;
    term_stall = 0;
    sh_width = 31'd65536;
    sh_coef = 0;
    sh_ref[0] = 0;
    sh_ref[1] = 0;
    sh_ref[2] = 0;
    sh_dims = 2'd3;
    fill_taper();
    repeat (10) @(posedge clk);
    rst <= 0;
    // reset defaults: coefficient zero gives zero terms
    pending_nodes.push_back('{31'd0, 31'h7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 32'sd5});
    drain();
    write_reg(REG_MAX_COEF, 32'h7fff_ffff);
    write_reg(REG_REF_VEL_X, 32'h7fff_ffff);
    write_reg(REG_REF_VEL_Y, 32'h8000_0000);
    write_reg(REG_REF_VEL_Z, 32'd12345);
    write_reg(REG_LAYER_WIDTH, 32'h0001_0000);
    write_reg(REG_DIMENSIONS, 32'd3);
    // wall, mid layer, just inside, at edge, outside, volume extremes
    pending_nodes.push_back('{31'd0, 31'h7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000});
    pending_nodes.push_back('{31'd0, 31'd1, 32'sd0, 32'sd0, 32'sd0});
    pending_nodes.push_back('{31'd0, 31'd0, 32'sd1, 32'sd1, 32'sd1});
    pending_nodes.push_back('{31'h8000, 31'h10000, 32'sd0, -32'sd1, 32'sd7});
    pending_nodes.push_back('{31'hffff, 31'h7fff_ffff, 32'sd3, 32'sd3, 32'sh7fff_ffff});
    pending_nodes.push_back('{31'h10000, 31'h7fff_ffff, 32'sd3, 32'sd3, 32'sd3});
    pending_nodes.push_back('{31'h7fff_ffff, 31'h7fff_ffff, 32'sd3, 32'sd3, 32'sd3});
    drain();
    write_reg(REG_DIMENSIONS, 32'd2);
    write_reg(REG_MAX_COEF, 32'h0000_4000);
    pending_nodes.push_back('{31'd100, 31'h0002_0000, 32'sd0, 32'sd0, -32'sd100000});
    pending_nodes.push_back('{31'd1, 31'h5555_5555, 32'shaaaa_aaaa, 32'sh5555_5555, 32'sd9});
    drain();
    write_reg(REG_DIMENSIONS, 32'd0);
    pending_nodes.push_back('{31'd1, 31'h0002_0000, 32'sd0, 32'sd0, -32'sd100000});
    drain();
    write_reg(REG_DIMENSIONS, 32'd1);
    pending_nodes.push_back('{31'd1, 31'h0002_0000, 32'sd0, 32'sd0, -32'sd100000});
    drain();
    write_reg(REG_LAYER_WIDTH, 32'd0);
    pending_nodes.push_back('{31'd0, 31'h7fff_ffff, 32'sd4, 32'sd4, 32'sd4});
    drain();
    write_reg(REG_LAYER_WIDTH, 32'hffff_ffff);
    write_reg(REG_DIMENSIONS, 32'd7);
    write_reg(3'd6, 32'd1);
    write_reg(3'd7, 32'd1);
    pending_nodes.push_back('{31'h7fff_fffe, 31'h7fff_ffff, 32'sd4, 32'sd4, 32'sd4});
    pending_nodes.push_back('{31'h4000_0000, 31'h7fff_ffff, 32'sd4, 32'sd4, 32'sd4});
    drain();
    for (int ph = 0; ph < 10; ph++) begin
      random_config();
      for (int k = 0; k < 75; k++) begin
        dn = rand_node($urandom_range(0, 4) != 0);
        pending_nodes.push_back(dn);
        if (k == 40 && ph == 3) begin
          // hold the sender until the pipe is empty
          while (pending_nodes.size() > 0 || node_valid) @(posedge clk);
          sender_hold = 1;
          while (expected_terms.size() > 0) @(posedge clk);
          sender_hold = 0;
        end
      end
      drain();
    end
    $display("covered %0d nodes over 10 random register settings plus directed edge cases",
             nodes_sent);
    $display("%0d terms checked", terms_seen);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

endmodule
